### sv/qfr_pkg.sv
`default_nettype none

package qfr_pkg;

  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned DivSteps    = 31;
  localparam int unsigned HornerSteps = 6;
  localparam int unsigned SinSteps    = 5;

  localparam logic [30:0] OneQ30 = 31'h4000_0000;
  localparam logic signed [31:0] QuatMax = 32'sd1073741824;
  localparam logic [33:0] HalfPiQ30    = 34'd1686629713;
  localparam logic [33:0] QuarterPiQ30 = 34'd843314856;

  // Division by a small constant is done as a multiply by a rounded-up
  // reciprocal; for a dividend below 2^30 the shifted product is exact.
  localparam int unsigned SinShift [SinSteps] = '{37, 37, 36, 35, 33};
  localparam logic [31:0] SinRecip [SinSteps] = '{
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int unsigned CosShift [HornerSteps] = '{38, 37, 36, 35, 34, 31};
  localparam logic [31:0] CosRecip [HornerSteps] = '{
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } qfr_quad_e;

  // Values that travel alongside the arithmetic of each stage.
  typedef struct packed {
    logic [2:0][31:0]   comp;
    logic               zero;
    logic [31:0]        ang;
    logic [32:0]        h;
    logic [2:0]         k;
    logic               neg;
    logic [29:0]        m;
    logic [29:0]        q;
    logic [30:0]        tsin;
    logic [30:0]        tcos;
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } qfr_side_t;

  function automatic logic [31:0] sat_q30(input logic signed [32:0] v);
    logic signed [32:0] lim;
    lim = 33'(QuatMax);
    if (v > lim) begin
      return 32'(lim);
    end else if (v < -lim) begin
      return 32'(-lim);
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

### sv/quaternion_from_rotation_vector_unit.sv
// Channel  Dir  Bits  Fields, lowest bits first
// s_axis   in   96    rot_x, rot_y, rot_z (signed Q4.28 radians)
// m_axis   out  128   quat_w, quat_x, quat_y, quat_z (signed Q2.30)
//
// One transaction per cycle while the output is not stalled; a vector accepted
// passes through 85 register stages before it leaves as an output transaction.
// The stages are those of the 32-stage square root, the six two-stage polynomial
// steps and the 31-stage rounding divider, plus squaring and reduction stages.
// Reset clears only the valid bits; data registers are not reset.
// When the output holds a result that is not taken, the whole pipeline freezes.
`default_nettype none

module quaternion_from_rotation_vector_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,   // rot_x, rot_y, rot_z
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // quat_w, quat_x, quat_y, quat_z
);
  import qfr_pkg::*;

  logic en;

  logic      s1_v_q;
  qfr_side_t s1_side_q, s1_side_d;
  logic [63:0] s1_sq_q [3];

  logic        sr_v_q    [SqrtSteps+1];
  logic [63:0] sr_op_q   [SqrtSteps+1];
  logic [63:0] sr_res_q  [SqrtSteps+1];
  qfr_side_t   sr_side_q [SqrtSteps+1];

  logic      r1_v_q, r2_v_q;
  qfr_side_t r1_side_q, r1_side_d, r2_side_q, r2_side_d;
  logic [33:0] hq;
  logic signed [34:0] r_red;

  logic      hz_v_q    [HornerSteps+1];
  qfr_side_t hz_side_q [HornerSteps+1];
  qfr_side_t hz0_side_d;
  logic [59:0] msq;
  logic      ha_v_q    [HornerSteps];
  qfr_side_t ha_side_q [HornerSteps];
  logic [60:0] pc_q [HornerSteps];
  logic [61:0] yc_q [HornerSteps];
  logic [60:0] ps_q [SinSteps];
  logic [61:0] ys_q [SinSteps];

  logic        p1_v_q, p2_v_q, p3_v_q;
  qfr_side_t   p1_side_q, p1_side_d, p2_side_q, p2_side_d, p3_side_q;
  logic [60:0] p1_sprod_q;
  logic [30:0] s_mag;
  logic signed [31:0] s_sgn, c_sgn;
  logic signed [63:0] p3_prod_q [3];

  logic        dv_v_q    [DivSteps+1];
  qfr_side_t   dv_side_q [DivSteps+1];
  logic [31:0] dv_rem_q  [DivSteps+1][3];
  logic [30:0] dv_quo_q  [DivSteps+1][3];
  logic [62:0] dv_num_q  [DivSteps+1][3];
  logic        dv_neg_q  [DivSteps+1][3];
  logic [62:0] p4_num [3];
  logic [61:0] p4_mag [3];

  logic         out_v_q;
  logic [127:0] out_data_q, out_data_d;

  // A single enable moves every stage, so nothing is dropped or doubled.
  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

  // Squares of the three components.
  always_comb begin
    s1_side_d      = '0;
    s1_side_d.comp = s_axis_tdata_i;
    s1_side_d.zero = (s_axis_tdata_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= s1_side_d;
      for (int j = 0; j < 3; j++) begin
        s1_sq_q[j] <= 64'($signed(s_axis_tdata_i[32*j +: 32]))
                    * 64'($signed(s_axis_tdata_i[32*j +: 32]));
      end
    end
  end

  // Sum of squares, then one root bit per stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_v_q[0] <= 1'b0;
    end else if (en) begin
      sr_v_q[0] <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_op_q[0]   <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
      sr_res_q[0]  <= '0;
      sr_side_q[0] <= s1_side_q;
    end
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    logic [63:0] trial, op_d, res_d;

    always_comb begin
      trial = sr_res_q[i] + Bit;
      if (sr_op_q[i] >= trial) begin
        op_d  = sr_op_q[i] - trial;
        res_d = (sr_res_q[i] >> 1) + Bit;
      end else begin
        op_d  = sr_op_q[i];
        res_d = sr_res_q[i] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[i+1] <= 1'b0;
      end else if (en) begin
        sr_v_q[i+1] <= sr_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_op_q[i+1]   <= op_d;
        sr_res_q[i+1]  <= res_d;
        sr_side_q[i+1] <= sr_side_q[i];
      end
    end
  end

  // Half angle and its quadrant count.
  always_comb begin
    r1_side_d     = sr_side_q[SqrtSteps];
    r1_side_d.ang = sr_res_q[SqrtSteps][31:0];
    r1_side_d.h   = {sr_res_q[SqrtSteps][31:0], 1'b0};
    hq            = 34'(r1_side_d.h) + QuarterPiQ30;
    r1_side_d.k   = 3'(hq >= HalfPiQ30) + 3'(hq >= 34'(2 * HalfPiQ30))
                  + 3'(hq >= 34'(3 * HalfPiQ30)) + 3'(hq >= 34'(4 * HalfPiQ30));
  end

  always_comb begin
    r2_side_d     = r1_side_q;
    r_red         = $signed({2'b00, r1_side_q.h})
                  - $signed({1'b0, HalfPiQ30 * 34'(r1_side_q.k)});
    r2_side_d.neg = r_red[34];
    r2_side_d.m   = r_red[34] ? 30'(-r_red) : 30'(r_red);
  end

  always_comb begin
    msq          = 60'(r2_side_q.m) * 60'(r2_side_q.m);
    hz0_side_d   = r2_side_q;
    hz0_side_d.q = msq[59:30];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q    <= 1'b0;
      r2_v_q    <= 1'b0;
      hz_v_q[0] <= 1'b0;
    end else if (en) begin
      r1_v_q    <= sr_v_q[SqrtSteps];
      r2_v_q    <= r1_v_q;
      hz_v_q[0] <= r2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_side_q    <= r1_side_d;
      r2_side_q    <= r2_side_d;
      hz_side_q[0] <= hz0_side_d;
    end
  end

  // Horner steps: product with q, then the constant division.
  for (genvar i = 0; i < HornerSteps; i++) begin : g_horner
    logic [30:0] tc;
    qfr_side_t   ha_side_d;

    if (i == 0) begin : g_first
      assign tc = OneQ30;
    end else begin : g_next
      assign tc = OneQ30 - 31'(yc_q[i-1] >> CosShift[i-1]);
    end

    if (i == SinSteps) begin : g_sin_end
      always_comb begin
        ha_side_d      = hz_side_q[i];
        ha_side_d.tsin = OneQ30 - 31'(ys_q[SinSteps-1] >> SinShift[SinSteps-1]);
      end
    end else begin : g_pass
      assign ha_side_d = hz_side_q[i];
    end

    if (i < SinSteps) begin : g_sin
      logic [30:0] ts;
      if (i == 0) begin : g_first
        assign ts = OneQ30;
      end else begin : g_next
        assign ts = OneQ30 - 31'(ys_q[i-1] >> SinShift[i-1]);
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          ps_q[i] <= 61'(hz_side_q[i].q) * 61'(ts);
          ys_q[i] <= 62'(ps_q[i][59:30]) * 62'(SinRecip[i]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ha_v_q[i]   <= 1'b0;
        hz_v_q[i+1] <= 1'b0;
      end else if (en) begin
        ha_v_q[i]   <= hz_v_q[i];
        hz_v_q[i+1] <= ha_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pc_q[i]        <= 61'(hz_side_q[i].q) * 61'(tc);
        ha_side_q[i]   <= ha_side_d;
        yc_q[i]        <= 62'(pc_q[i][59:30]) * 62'(CosRecip[i]);
        hz_side_q[i+1] <= ha_side_q[i];
      end
    end
  end

  // Sine and cosine of the reduced angle, then the quadrant.
  always_comb begin
    p1_side_d      = hz_side_q[HornerSteps];
    p1_side_d.tcos = OneQ30 - 31'(yc_q[HornerSteps-1] >> CosShift[HornerSteps-1]);
  end

  always_comb begin
    s_mag     = p1_sprod_q[60:30];
    s_sgn     = p1_side_q.neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    c_sgn     = $signed({1'b0, p1_side_q.tcos});
    p2_side_d = p1_side_q;
    unique case (qfr_quad_e'(p1_side_q.k[1:0]))
      QUAD_0: begin
        p2_side_d.sn = s_sgn;
        p2_side_d.cs = c_sgn;
      end
      QUAD_1: begin
        p2_side_d.sn = c_sgn;
        p2_side_d.cs = -s_sgn;
      end
      QUAD_2: begin
        p2_side_d.sn = -s_sgn;
        p2_side_d.cs = -c_sgn;
      end
      QUAD_3: begin
        p2_side_d.sn = -c_sgn;
        p2_side_d.cs = s_sgn;
      end
    endcase
  end

  // Rounded dividend: magnitude of the product plus half the angle.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p4_mag[j] = p3_prod_q[j][63] ? 62'(-p3_prod_q[j]) : 62'(p3_prod_q[j]);
      p4_num[j] = 63'(p4_mag[j]) + 63'(p3_side_q.ang >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q    <= 1'b0;
      p2_v_q    <= 1'b0;
      p3_v_q    <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      p1_v_q    <= hz_v_q[HornerSteps];
      p2_v_q    <= p1_v_q;
      p3_v_q    <= p2_v_q;
      dv_v_q[0] <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q    <= p1_side_d;
      p1_sprod_q   <= 61'(hz_side_q[HornerSteps].m) * 61'(hz_side_q[HornerSteps].tsin);
      p2_side_q    <= p2_side_d;
      p3_side_q    <= p2_side_q;
      dv_side_q[0] <= p3_side_q;
      for (int j = 0; j < 3; j++) begin
        p3_prod_q[j]   <= 64'($signed(p2_side_q.comp[j])) * 64'(p2_side_q.sn);
        dv_rem_q[0][j] <= p4_num[j][62:31];
        dv_quo_q[0][j] <= '0;
        dv_num_q[0][j] <= p4_num[j];
        dv_neg_q[0][j] <= p3_prod_q[j][63];
      end
    end
  end

  // Restoring division by the angle, one quotient bit per stage.
  for (genvar d = 0; d < DivSteps; d++) begin : g_div
    localparam int unsigned Bidx = DivSteps - 1 - d;
    logic [32:0] pr   [3];
    logic [31:0] rem_d [3];
    logic [30:0] quo_d [3];

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        pr[j] = {dv_rem_q[d][j], dv_num_q[d][j][Bidx]};
        if (pr[j] >= {1'b0, dv_side_q[d].ang}) begin
          rem_d[j] = 32'(pr[j] - {1'b0, dv_side_q[d].ang});
          quo_d[j] = {dv_quo_q[d][j][29:0], 1'b1};
        end else begin
          rem_d[j] = pr[j][31:0];
          quo_d[j] = {dv_quo_q[d][j][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[d+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[d+1] <= dv_v_q[d];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_side_q[d+1] <= dv_side_q[d];
        for (int j = 0; j < 3; j++) begin
          dv_rem_q[d+1][j] <= rem_d[j];
          dv_quo_q[d+1][j] <= quo_d[j];
          dv_num_q[d+1][j] <= dv_num_q[d][j];
          dv_neg_q[d+1][j] <= dv_neg_q[d][j];
        end
      end
    end
  end

  // Sign, saturation and the zero-vector case.
  always_comb begin
    logic signed [32:0] qv;
    out_data_d       = '0;
    out_data_d[31:0] = sat_q30(33'(dv_side_q[DivSteps].cs));
    for (int j = 0; j < 3; j++) begin
      qv = $signed({2'b00, dv_quo_q[DivSteps][j]});
      out_data_d[32*(j+1) +: 32] = sat_q30(dv_neg_q[DivSteps][j] ? -qv : qv);
    end
    if (dv_side_q[DivSteps].zero) begin
      out_data_d       = '0;
      out_data_d[31:0] = QuatMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

### sv/qfr_checker.sv
`default_nettype none

module qfr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tready_i,
  input logic         m_tvalid_i,
  input logic         m_tready_i,
  input logic [127:0] m_tdata_i
);
  import qfr_pkg::*;

  logic [3:0] lane_ok;

  always_comb begin
    logic signed [31:0] lane;
    for (int l = 0; l < 4; l++) begin
      lane       = $signed(m_tdata_i[32*l +: 32]);
      lane_ok[l] = (lane <= QuatMax) && (lane >= -QuatMax);
    end
  end

  // A held result must not change until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("output transaction changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> lane_ok == 4'hF)
    else $error("quaternion lane outside unit range");

  // The pipeline only stops when the output is blocked.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tready_i |-> s_tready_i)
    else $error("input stalled while output is free");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_tvalid_i)
    else $error("output valid during reset");

endmodule

bind quaternion_from_rotation_vector_unit qfr_checker u_qfr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned PipeLatency = 85;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned RandItems   = 1630;
  localparam longint One30     = 64'sd1073741824;
  localparam longint HalfPi30  = 64'sd1686629713;
  localparam longint QuartPi30 = 64'sd843314856;

  typedef struct {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } quat_t;

  typedef struct {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic        has_exp;
    quat_t       exp_q;
  } vec_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [127:0] m_axis_tdata_o;

  quaternion_from_rotation_vector_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  quat_t       pending_quats[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          snk_hold;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint sat_unit(input longint v);
    if (v > One30) return One30;
    if (v < -One30) return -One30;
    return v;
  endfunction

  function automatic longint poly_eval(input longint q, input bit is_sin);
    longint t;
    int     n;
    longint d;
    t = One30;
    n = is_sin ? 5 : 6;
    for (int i = 0; i < n; i++) begin
      if (is_sin) begin
        case (i)
          0: d = 110; 1: d = 72; 2: d = 42; 3: d = 20; default: d = 6;
        endcase
      end else begin
        case (i)
          0: d = 132; 1: d = 90; 2: d = 56; 3: d = 30; 4: d = 12; default: d = 2;
        endcase
      end
      t = One30 - ((q * t) >>> 30) / d;
    end
    return t;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic quat_t rotvec_to_quat(input logic [31:0] rx, input logic [31:0] ry,
                                           input logic [31:0] rz);
    quat_t           res;
    longint          comp[3];
    longint unsigned sum;
    longint          ang, h, k, r, m, q, s, c, sn, cs, p, v;
    longint unsigned mag;
    logic [31:0]     outv[3];
    comp[0] = longint'($signed(rx));
    comp[1] = longint'($signed(ry));
    comp[2] = longint'($signed(rz));
    sum = 0;
    for (int j = 0; j < 3; j++) sum += longint'(comp[j] * comp[j]);
    if (sum == 0) begin
      res.w = 32'(One30);
      res.x = '0;
      res.y = '0;
      res.z = '0;
      return res;
    end
    ang = longint'(int_sqrt(sum));
    h = ang * 2;
    k = (h + QuartPi30) / HalfPi30;
    r = h - k * HalfPi30;
    m = (r < 0) ? -r : r;
    q = (m * m) >>> 30;
    s = (m * poly_eval(q, 1'b1)) >>> 30;
    if (r < 0) s = -s;
    c = poly_eval(q, 1'b0);
    case (k & 3)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    res.w = 32'(sat_unit(cs));
    for (int j = 0; j < 3; j++) begin
      p = comp[j] * sn;
      mag = (p < 0) ? longint'(-p) : longint'(p);
      v = longint'((mag + longint'(ang) / 2) / longint'(ang));
      outv[j] = 32'(sat_unit((p < 0) ? -v : v));
    end
    res.x = outv[0];
    res.y = outv[1];
    res.z = outv[2];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Send one vector; the prediction is queued when the transaction completes.
  // Valid stays high on return, so the caller drops it after the last vector.
  task automatic send_vector(input logic [31:0] rx, input logic [31:0] ry,
                             input logic [31:0] rz, input bit has_exp, input quat_t exp_q);
    quat_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {rz, ry, rx};
    pred = has_exp ? exp_q : rotvec_to_quat(rx, ry, rz);
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_quats.push_back(pred);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom_range(32'h3000_0000)) - 32'sh1800_0000);
      default: return 32'($signed($urandom_range(32'h0C00_0000)) - 32'sh0600_0000);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (snk_hold) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.w = m_axis_tdata_o[31:0];
      got.x = m_axis_tdata_o[63:32];
      got.y = m_axis_tdata_o[95:64];
      got.z = m_axis_tdata_o[127:96];
      if (pending_quats.size() == 0) begin
        report_mismatch("result with no vector outstanding", got.w, '0);
      end else begin
        want = pending_quats.pop_front();
        if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
        if (got.x !== want.x) report_mismatch("quat_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("quat_y", got.y, want.y);
        if (got.z !== want.z) report_mismatch("quat_z", got.z, want.z);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    vec_row_t    vec_table[$];
    quat_t       ident, nada;
    int unsigned hold_len;
    ident = '{w: 32'h4000_0000, x: '0, y: '0, z: '0};
    nada  = '{w: '0, x: '0, y: '0, z: '0};
    error_count     = 0;
    idle_cycles     = 0;
    src_idle_pct    = 0;
    snk_idle_pct    = 0;
    snk_hold        = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;

    vec_table = '{
      '{32'h0, 32'h0, 32'h0, 1'b1, ident},
      '{32'h1, 32'h0, 32'h0, 1'b0, nada},
      '{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, nada},
      '{32'h0, 32'h1000_0000, 32'h0, 1'b0, nada},
      '{32'h0, 32'h0, 32'h3243_F6A9, 1'b0, nada},
      '{32'hCDBC_0957, 32'h0, 32'h0, 1'b0, nada},
      '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, nada},
      '{32'h8000_0000, 32'h0, 32'h0, 1'b0, nada},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, nada},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, nada},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, nada},
      '{32'h0, 32'h6487_ED51, 32'h0, 1'b0, nada},
      '{32'h0, 32'h0, 32'h9687_E3F0, 1'b0, nada},
      '{32'h1921_FB54, 32'h1921_FB54, 32'h0, 1'b0, nada},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, nada},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, nada},
      '{32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0002, 1'b0, nada},
      '{32'h0004_0000, 32'h0, 32'hFFFC_0000, 1'b0, nada},
      '{32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 1'b0, nada}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (vec_table[i]) begin
      send_vector(vec_table[i].rx, vec_table[i].ry, vec_table[i].rz,
                  vec_table[i].has_exp, vec_table[i].exp_q);
    end

    // Long receiver stall while vectors keep coming, to back the pipeline up.
    fork
      begin
        snk_hold = 1'b1;
        hold_len = 300;
        repeat (hold_len) @(posedge clk_i);
        snk_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 120; i++) send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, nada);
        s_axis_tvalid_i <= 1'b0;
      end
    join
    @(negedge clk_i);

    for (int i = 0; i < RandItems - 120; i++) begin
      if (i == 0) begin
        src_idle_pct = 12;
        snk_idle_pct = 54;
      end else if (i == 500) begin
        src_idle_pct = 54;
        snk_idle_pct = 12;
      end else if (i == 1000) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, nada);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
